// File: src/bdq_pkg.sv
// Shared types and constants for the bounded deque ring.
package bdq_pkg;

    localparam int unsigned DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        OP_INS_TAIL = 3'd0,
        OP_INS_HEAD = 3'd1,
        OP_DEL_HEAD = 3'd2,
        OP_DEL_TAIL = 3'd3,
        OP_SHOW     = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SHOW
    } t_state;

    typedef struct packed {
        logic    ins_tail;
        logic    ins_head;
        logic    del_head;
        logic    del_tail;
        logic    ld_status;
        t_status status;
        logic    show_start;
        logic    show_step;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic at_last;
        logic slot_free;
    } t_dp_sts;

endpackage

// File: src/bdq_if.sv
// Valid/ready channel interfaces for operation requests and results.
interface bdq_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink (input valid, input operation, input value, output ready);
endinterface

interface bdq_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;

    modport source (output valid, output item_value, output status, output last, input ready);
    modport sink (input valid, input item_value, input status, input last, output ready);
endinterface

// File: src/bdq_ctrl.sv
// Controller state machine: decodes operations and sequences the display stream.
module bdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [2:0]       i_operation,
    input  bdq_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output bdq_pkg::t_dp_cmd o_cmd
);
    import bdq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.slot_free && t_op'(i_operation) == OP_SHOW
                        && !i_sts.empty) begin
                    n_state = S_SHOW;
                end
            end
            S_SHOW: begin
                if (i_sts.slot_free && i_sts.at_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_sts.slot_free;
                if (i_in_valid && i_sts.slot_free) begin
                    case (t_op'(i_operation))
                        OP_INS_TAIL, OP_INS_HEAD: begin
                            o_cmd.ld_status = 1'b1;
                            if (i_sts.full) begin
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.ins_tail = (t_op'(i_operation) == OP_INS_TAIL);
                                o_cmd.ins_head = (t_op'(i_operation) == OP_INS_HEAD);
                            end
                        end
                        OP_DEL_HEAD, OP_DEL_TAIL: begin
                            o_cmd.ld_status = 1'b1;
                            if (i_sts.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.del_head = (t_op'(i_operation) == OP_DEL_HEAD);
                                o_cmd.del_tail = (t_op'(i_operation) == OP_DEL_TAIL);
                            end
                        end
                        OP_SHOW: begin
                            if (i_sts.empty) begin
                                o_cmd.ld_status = 1'b1;
                                o_cmd.status    = ST_EMPTY;
                            end else begin
                                o_cmd.show_start = 1'b1;
                            end
                        end
                        default: begin
                            // undefined codes are dropped silently
                        end
                    endcase
                end
            end
            S_SHOW: begin
                o_cmd.show_step = i_sts.slot_free;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: src/bdq_dp.sv
// Datapath: ring store, head and count pointers, display index, output register.
module bdq_dp #(
    parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdq_pkg::t_dp_cmd   i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_out_ready,
    output bdq_pkg::t_dp_sts   o_sts,
    output logic               o_out_valid,
    output logic signed [31:0] o_item_value,
    output bdq_pkg::t_status   o_status,
    output logic               o_last
);
    import bdq_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_POS = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW:0]   WRAP_VAL = (CW + 1)'(DEPTH);

    function automatic logic [IW-1:0] f_wrap(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= WRAP_VAL) begin
            sum = sum - WRAP_VAL;
        end
        return sum[IW-1:0];
    endfunction

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [IW-1:0]      r_head;
    logic [IW-1:0]      n_head;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [IW-1:0]      r_idx;
    logic               r_out_valid;
    logic signed [31:0] r_item_value;
    t_status            r_status;
    logic               r_last;

    logic [IW-1:0] head_dec;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;
    logic [CW-1:0] idx_inc;
    logic          at_last;
    logic          slot_free;

    assign head_dec  = (r_head == '0) ? LAST_POS : r_head - 1'b1;
    assign idx_inc   = CW'(r_idx) + CW'(1);
    assign at_last   = (idx_inc == r_count);
    assign slot_free = !r_out_valid || i_out_ready;
    assign wr_en     = i_cmd.ins_tail || i_cmd.ins_head;
    assign wr_addr   = i_cmd.ins_head ? head_dec : f_wrap(r_head, r_count);
    assign rd_en     = i_cmd.show_start || i_cmd.show_step;
    assign rd_addr   = i_cmd.show_start ? r_head : f_wrap(r_head, idx_inc);

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.ins_head) begin
            n_head = head_dec;
        end else if (i_cmd.del_head) begin
            n_head = f_wrap(r_head, CW'(1));
        end
        if (wr_en) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.del_head || i_cmd.del_tail) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            if (i_cmd.ld_status || i_cmd.show_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.show_start) begin
            r_idx <= '0;
        end else if (i_cmd.show_step) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.ld_status) begin
            r_item_value <= '0;
            r_status     <= i_cmd.status;
            r_last       <= 1'b1;
        end else if (i_cmd.show_step) begin
            r_item_value <= r_rd_data;
            r_status     <= ST_OK;
            r_last       <= at_last;
        end
    end

    assign o_sts.full      = (r_count == FULL_CNT);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.at_last   = at_last;
    assign o_sts.slot_free = slot_free;

    assign o_out_valid  = r_out_valid;
    assign o_item_value = r_item_value;
    assign o_status     = r_status;
    assign o_last       = r_last;

endmodule

// File: src/bounded_deque_ring.sv
// Insert, delete and empty-display status results appear in the cycle after the input transfer.
// Insert and delete accept one item per cycle while results are taken each cycle.
// Display of N entries from the single-port ring store via read data and output registers,
// one per cycle while results are taken; input is held off until the last value is registered.
// Synchronous active-low reset clears head, count, FSM and output valid; store is not cleared.
module bounded_deque_ring #(
    parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdq_in_if.sink     i_in,
    bdq_out_if.source  o_out
);
    import bdq_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_status out_status;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_cmd       (cmd)
    );

    bdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_in.value),
        .i_out_ready  (o_out.ready),
        .o_sts        (sts),
        .o_out_valid  (o_out.valid),
        .o_item_value (o_out.item_value),
        .o_status     (out_status),
        .o_last       (o_out.last)
    );

    assign o_out.status = out_status;

`ifndef SYNTHESIS
    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !(o_out.valid && !o_out.ready))
        else $error("input transfer while result still pending");

    a_insert_reports_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.ins_tail || cmd.ins_head) |=> (o_out.valid && o_out.status == ST_OK && o_out.last))
        else $error("insert did not produce ok status");

    a_show_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.show_start || (cmd.show_step && !sts.at_last)) |=> !i_in.ready)
        else $error("input accepted during display stream");
`endif

endmodule
